[src/cfd_pkg.sv]
package cfd_pkg;

   // Parse phase: one code per header or checksum byte position, one shared code for all payload bytes
   typedef enum logic [3:0] {
      PH_HUNT  = 4'd0,
      PH_COMPL = 4'd1,
      PH_CMD_H = 4'd2,
      PH_CMD_L = 4'd3,
      PH_EXT_H = 4'd4,
      PH_EXT_L = 4'd5,
      PH_LEN_H = 4'd6,
      PH_LEN_L = 4'd7,
      PH_DATA  = 4'd8,
      PH_SUM_L = 4'd9,
      PH_SUM_H = 4'd10
   } phase_type;

   // Pulse from the parser when the second checksum byte is taken
   typedef struct packed {
      logic done;
      logic good;
   } frame_end_type;

   localparam logic [7:0]  COMPL_SUM    = 8'hFF;
   localparam logic [15:0] LEN_OVERHEAD = 16'd2;
   localparam logic [15:0] MIN_PAYLOAD  = 16'd1;
   localparam logic        STATUS_OK    = 1'b0;
   localparam logic        STATUS_BAD   = 1'b1;
   localparam int unsigned INDEX_W      = 6;

endpackage

[src/checksummed_frame_deframer.sv]
// Byte-stream frame parser with a 16-bit additive checksum. Each req beat
// carries one received byte: transaction byte, its complement, command,
// extra word and length (all high byte first), then max(length-2,1) payload
// bytes held in an on-chip payload memory of BUFFER_DEPTH bytes, then the
// checksum low byte first. A good frame produces one rsp beat per payload
// byte with the header fields attached; a bad checksum produces one beat
// with status set and last set. A bad complement or a payload longer than
// the buffer silently drops the frame and hunting resumes. Rate: one byte
// per cycle while parsing. After the last checksum byte, req_stall stays
// high while the payload drains through the single memory read port at one
// beat per cycle while rsp_stall is low; for an error frame it stays high
// until the error beat has moved on to the result register. Either hold
// lasts longer while rsp_stall is asserted. No clearing pass runs after
// reset.
module checksummed_frame_deframer #(
   parameter int unsigned BUFFER_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [7:0]  rsp_transaction,
   output logic [15:0] rsp_command_word,
   output logic [15:0] rsp_extra_word,
   output logic [7:0]  rsp_payload_byte,
   output logic [5:0]  rsp_byte_index,
   output logic        rsp_last
);
   import cfd_pkg::*;

   localparam int unsigned ADDR_W  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int unsigned COUNT_W = $clog2(BUFFER_DEPTH + 1);

   logic               byte_take;
   logic               drain_busy;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [7:0]         wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [7:0]         rd_data;
   logic [7:0]         hdr_trans;
   logic [15:0]        hdr_cmd;
   logic [15:0]        hdr_extra;
   logic [COUNT_W-1:0] payload_count;
   frame_end_type      frame_end;

   // input holds off while the payload memory is being read out; this also
   // keeps the header registers steady for every beat of the drain
   assign req_stall = drain_busy;
   assign byte_take = req_valid && !drain_busy;

   cfd_parser #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .ADDR_W       (ADDR_W),
      .COUNT_W      (COUNT_W)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .byte_take     (byte_take),
      .rx_byte       (req_rx_byte),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .transaction   (hdr_trans),
      .command_word  (hdr_cmd),
      .extra_word    (hdr_extra),
      .payload_count (payload_count),
      .frame_end     (frame_end)
   );

   cfd_payload_mem #(
      .DEPTH  (BUFFER_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cfd_drain #(
      .ADDR_W  (ADDR_W),
      .COUNT_W (COUNT_W)
   ) u_drain (
      .clock            (clock),
      .reset            (reset),
      .frame_end        (frame_end),
      .payload_count    (payload_count),
      .transaction      (hdr_trans),
      .command_word     (hdr_cmd),
      .extra_word       (hdr_extra),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .busy             (drain_busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_transaction  (rsp_transaction),
      .rsp_command_word (rsp_command_word),
      .rsp_extra_word   (rsp_extra_word),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_last         (rsp_last)
   );

   // memory is never written and read in the same cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("payload memory write during drain");

   // a finished frame always leaves work for the drain
   a_end_starts_drain: assert property (@(posedge clock) disable iff (reset)
      frame_end.done |=> req_stall)
      else $error("frame end did not start a drain");

   // an error beat is a lone, zeroed, final beat
   a_err_beat_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_BAD) |->
         (rsp_last && rsp_payload_byte == 8'd0 && rsp_byte_index == 6'd0))
      else $error("malformed error beat");
endmodule

[src/cfd_payload_mem.sv]
module cfd_payload_mem #(
   parameter int unsigned DEPTH  = 64,
   parameter int unsigned ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);
   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[src/cfd_parser.sv]
module cfd_parser #(
   parameter int unsigned BUFFER_DEPTH = 64,
   parameter int unsigned ADDR_W       = 6,
   parameter int unsigned COUNT_W      = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_take,
   input  logic [7:0]            rx_byte,
   output logic                  wr_en,
   output logic [ADDR_W-1:0]     wr_addr,
   output logic [7:0]            wr_data,
   output logic [7:0]            transaction,
   output logic [15:0]           command_word,
   output logic [15:0]           extra_word,
   output logic [COUNT_W-1:0]    payload_count,
   output cfd_pkg::frame_end_type frame_end
);
   import cfd_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [15:0]        sum_ff;
   logic [7:0]         trans_ff;
   logic [15:0]        cmd_ff;
   logic [15:0]        extra_ff;
   logic [15:0]        len_ff;
   logic [7:0]         sum_lo_ff;
   logic [COUNT_W-1:0] count_ff;

   logic [COUNT_W-1:0] count_inc;
   logic               room;
   logic [15:0]        need;
   logic               data_full;
   logic               compl_ok;
   logic [15:0]        sum_add;

   assign count_inc = count_ff + COUNT_W'(1);
   assign room      = count_ff < COUNT_W'(BUFFER_DEPTH);
   assign need      = (len_ff > LEN_OVERHEAD) ? (len_ff - LEN_OVERHEAD) : MIN_PAYLOAD;
   assign data_full = 16'(count_inc) >= need;
   assign compl_ok  = ({1'b0, trans_ff} + {1'b0, rx_byte}) == {1'b0, COMPL_SUM};
   assign sum_add   = sum_ff + 16'(rx_byte);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (byte_take) begin
         unique case (phase_ff)
            PH_COMPL: phase_in = compl_ok ? PH_CMD_H : PH_HUNT;
            PH_CMD_H: phase_in = PH_CMD_L;
            PH_CMD_L: phase_in = PH_EXT_H;
            PH_EXT_H: phase_in = PH_EXT_L;
            PH_EXT_L: phase_in = PH_LEN_H;
            PH_LEN_H: phase_in = PH_LEN_L;
            PH_LEN_L: phase_in = PH_DATA;
            PH_DATA: begin
               if (!room) begin
                  phase_in = PH_HUNT;
               end else if (data_full) begin
                  phase_in = PH_SUM_L;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_SUM_L: phase_in = PH_SUM_H;
            PH_SUM_H: phase_in = PH_HUNT;
            default:  phase_in = PH_COMPL;
         endcase
      end
   end

   // outputs
   always_comb begin
      wr_en          = byte_take && (phase_ff == PH_DATA) && room;
      wr_addr        = count_ff[ADDR_W-1:0];
      wr_data        = rx_byte;
      frame_end.done = byte_take && (phase_ff == PH_SUM_H);
      frame_end.good = {rx_byte, sum_lo_ff} == sum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         trans_ff  <= '0;
         cmd_ff    <= '0;
         extra_ff  <= '0;
         len_ff    <= '0;
         sum_lo_ff <= '0;
         count_ff  <= '0;
      end else if (byte_take) begin
         unique case (phase_ff)
            PH_COMPL: sum_ff <= sum_add;
            PH_CMD_H: begin
               sum_ff        <= sum_add;
               cmd_ff[15:8]  <= rx_byte;
            end
            PH_CMD_L: begin
               sum_ff        <= sum_add;
               cmd_ff[7:0]   <= rx_byte;
            end
            PH_EXT_H: begin
               sum_ff         <= sum_add;
               extra_ff[15:8] <= rx_byte;
            end
            PH_EXT_L: begin
               sum_ff         <= sum_add;
               extra_ff[7:0]  <= rx_byte;
            end
            PH_LEN_H: begin
               sum_ff        <= sum_add;
               len_ff[15:8]  <= rx_byte;
            end
            PH_LEN_L: begin
               sum_ff        <= sum_add;
               len_ff[7:0]   <= rx_byte;
            end
            PH_DATA: begin
               sum_ff <= sum_add;
               if (room) begin
                  count_ff <= count_inc;
               end
            end
            PH_SUM_L: sum_lo_ff <= rx_byte;
            PH_SUM_H: ;
            default: begin
               // hunting: frame start
               trans_ff <= rx_byte;
               sum_ff   <= 16'(rx_byte);
               count_ff <= '0;
            end
         endcase
      end
   end

   assign transaction   = trans_ff;
   assign command_word  = cmd_ff;
   assign extra_word    = extra_ff;
   assign payload_count = count_ff;
endmodule

[src/cfd_drain.sv]
module cfd_drain #(
   parameter int unsigned ADDR_W  = 6,
   parameter int unsigned COUNT_W = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfd_pkg::frame_end_type frame_end,
   input  logic [COUNT_W-1:0]     payload_count,
   input  logic [7:0]             transaction,
   input  logic [15:0]            command_word,
   input  logic [15:0]            extra_word,
   output logic                   rd_en,
   output logic [ADDR_W-1:0]      rd_addr,
   input  logic [7:0]             rd_data,
   output logic                   busy,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_status,
   output logic [7:0]             rsp_transaction,
   output logic [15:0]            rsp_command_word,
   output logic [15:0]            rsp_extra_word,
   output logic [7:0]             rsp_payload_byte,
   output logic [5:0]             rsp_byte_index,
   output logic                   rsp_last
);
   import cfd_pkg::*;

   logic [COUNT_W-1:0] remain_ff;
   logic [COUNT_W-1:0] rd_idx_ff;
   // read stage: memory data lands here
   logic               s1_valid_ff;
   logic               s1_err_ff;
   logic [INDEX_W-1:0] s1_idx_ff;
   logic               s1_last_ff;
   // result register
   logic               out_valid_ff;
   logic               out_status_ff;
   logic [7:0]         out_trans_ff;
   logic [15:0]        out_cmd_ff;
   logic [15:0]        out_extra_ff;
   logic [7:0]         out_payload_ff;
   logic [INDEX_W-1:0] out_idx_ff;
   logic               out_last_ff;

   logic out_free;
   logic s1_adv;
   logic issue;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign s1_adv   = s1_valid_ff && out_free;
   assign issue    = (remain_ff != '0) && (!s1_valid_ff || out_free);
   assign rd_en    = issue;
   assign rd_addr  = rd_idx_ff[ADDR_W-1:0];
   assign busy     = (remain_ff != '0) || s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff   <= '0;
         rd_idx_ff   <= '0;
         s1_valid_ff <= 1'b0;
         s1_err_ff   <= 1'b0;
         s1_idx_ff   <= '0;
         s1_last_ff  <= 1'b0;
      end else begin
         priority if (frame_end.done && frame_end.good) begin
            remain_ff <= payload_count;
            rd_idx_ff <= '0;
         end else if (frame_end.done) begin
            s1_valid_ff <= 1'b1;
            s1_err_ff   <= 1'b1;
            s1_idx_ff   <= '0;
            s1_last_ff  <= 1'b1;
         end else if (issue) begin
            remain_ff   <= remain_ff - COUNT_W'(1);
            rd_idx_ff   <= rd_idx_ff + COUNT_W'(1);
            s1_valid_ff <= 1'b1;
            s1_err_ff   <= 1'b0;
            s1_idx_ff   <= INDEX_W'(rd_idx_ff);
            s1_last_ff  <= remain_ff == COUNT_W'(1);
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end else begin
            s1_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_status_ff  <= s1_err_ff ? STATUS_BAD : STATUS_OK;
         out_trans_ff   <= transaction;
         out_cmd_ff     <= command_word;
         out_extra_ff   <= extra_word;
         out_payload_ff <= s1_err_ff ? 8'd0 : rd_data;
         out_idx_ff     <= s1_idx_ff;
         out_last_ff    <= s1_last_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_transaction  = out_trans_ff;
   assign rsp_command_word = out_cmd_ff;
   assign rsp_extra_word   = out_extra_ff;
   assign rsp_payload_byte = out_payload_ff;
   assign rsp_byte_index   = out_idx_ff;
   assign rsp_last         = out_last_ff;
endmodule

[bench/checksummed_frame_deframer_test.sv]
`timescale 1ns / 1ps

module checksummed_frame_deframer_test;
   import cfd_pkg::*;

   localparam int unsigned BUFFER_DEPTH = 64;

   // One result beat as the block should present it
   typedef struct {
      logic        status;
      logic [7:0]  transaction;
      logic [15:0] command_word;
      logic [15:0] extra_word;
      logic [7:0]  payload_byte;
      logic [5:0]  byte_index;
      logic        last;
   } frame_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_status;
   logic [7:0]  rsp_transaction;
   logic [15:0] rsp_command_word;
   logic [15:0] rsp_extra_word;
   logic [7:0]  rsp_payload_byte;
   logic [5:0]  rsp_byte_index;
   logic        rsp_last;

   // Bytes still to be offered, and result beats still owed by the block
   logic [7:0]     rx_bytes_pending [$];
   frame_beat_type expected_beats [$];

   int unsigned errors = 0;
   int unsigned bytes_in = 0;    // accepted req beats
   logic        byte_taken = 1'b0;

   // Idle-free window for both sides, keyed to input progress
   logic quiet;
   assign quiet = (bytes_in >= 150) && (bytes_in < 230);

   // Receiver hold-off: one long stretch with rsp_stall high
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;

   // Parser mirror
   phase_type   phase = PH_HUNT;
   logic [15:0] frame_sum = 16'h0000;
   logic [7:0]  frame_trans = 8'h00;
   logic [15:0] frame_cmd = 16'h0000;
   logic [15:0] frame_ext = 16'h0000;
   logic [15:0] frame_len = 16'h0000;
   logic [7:0]  sum_low = 8'h00;
   logic [6:0]  stored_count = 7'd0;
   logic [7:0]  payload_mem [BUFFER_DEPTH];

   checksummed_frame_deframer #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_transaction  (rsp_transaction),
      .rsp_command_word (rsp_command_word),
      .rsp_extra_word   (rsp_extra_word),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   task automatic log_mismatch(input string what);
      errors++;
      $display("ERROR at %0t: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) log_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   // Advance the parser mirror by one received byte and queue any result
   // beats it produces (only the second checksum byte produces any).
   task automatic parse_rx_byte(input logic [7:0] b);
      logic [15:0] need;
      int          i;
      case (phase)
         PH_COMPL: begin
            frame_sum += 16'(b);
            // complement check is on the full sum, not an 8-bit wrap
            phase = (({1'b0, frame_trans} + {1'b0, b}) == {1'b0, COMPL_SUM}) ?
                    PH_CMD_H : PH_HUNT;
         end
         PH_CMD_H: begin
            frame_sum += 16'(b);
            frame_cmd[15:8] = b;
            phase = PH_CMD_L;
         end
         PH_CMD_L: begin
            frame_sum += 16'(b);
            frame_cmd[7:0] = b;
            phase = PH_EXT_H;
         end
         PH_EXT_H: begin
            frame_sum += 16'(b);
            frame_ext[15:8] = b;
            phase = PH_EXT_L;
         end
         PH_EXT_L: begin
            frame_sum += 16'(b);
            frame_ext[7:0] = b;
            phase = PH_LEN_H;
         end
         PH_LEN_H: begin
            frame_sum += 16'(b);
            frame_len[15:8] = b;
            phase = PH_LEN_L;
         end
         PH_LEN_L: begin
            frame_sum += 16'(b);
            frame_len[7:0] = b;
            phase = PH_DATA;
         end
         PH_DATA: begin
            // lengths up to two still carry one payload byte
            need = (frame_len > LEN_OVERHEAD) ? frame_len - LEN_OVERHEAD : MIN_PAYLOAD;
            frame_sum += 16'(b);
            if (stored_count < BUFFER_DEPTH) begin
               payload_mem[stored_count[5:0]] = b;
               stored_count++;
               if (16'(stored_count) >= need) phase = PH_SUM_L;
            end else begin
               // one byte past a full buffer: frame dropped silently
               phase = PH_HUNT;
            end
         end
         PH_SUM_L: begin
            sum_low = b;
            phase = PH_SUM_H;
         end
         PH_SUM_H: begin
            phase = PH_HUNT;
            if ({b, sum_low} == frame_sum) begin
               for (i = 0; i < stored_count; i++) begin
                  expected_beats.push_back('{STATUS_OK, frame_trans, frame_cmd, frame_ext,
                                             payload_mem[i], 6'(i),
                                             (i + 1 == stored_count)});
               end
            end else begin
               expected_beats.push_back('{STATUS_BAD, frame_trans, frame_cmd, frame_ext,
                                          8'h00, 6'd0, 1'b1});
            end
         end
         default: begin
            // hunting: every byte here opens a new frame
            frame_trans = b;
            frame_sum = 16'(b);
            stored_count = 7'd0;
            phase = PH_COMPL;
         end
      endcase
   endtask

   // Queue one frame's bytes. fill < 0 gives random payload, else a constant.
   // Without with_sum the frame stops after the payload (overflow case).
   task automatic queue_frame(input logic [7:0] t, input logic [7:0] c,
                              input logic [15:0] cmd, input logic [15:0] ext,
                              input logic [15:0] len, input int n_data, input int fill,
                              input bit with_sum, input bit bad_sum);
      logic [7:0]  hdr [8];
      logic [7:0]  d;
      logic [15:0] s;
      hdr = '{t, c, cmd[15:8], cmd[7:0], ext[15:8], ext[7:0], len[15:8], len[7:0]};
      s = 16'h0000;
      foreach (hdr[k]) begin
         rx_bytes_pending.push_back(hdr[k]);
         s += 16'(hdr[k]);
      end
      for (int k = 0; k < n_data; k++) begin
         d = (fill < 0) ? 8'($urandom) : 8'(fill);
         rx_bytes_pending.push_back(d);
         s += 16'(d);
      end
      if (with_sum) begin
         if (bad_sum) s ^= 16'($urandom_range(1, 65535));
         rx_bytes_pending.push_back(s[7:0]);
         rx_bytes_pending.push_back(s[15:8]);
      end
   endtask

   // Well-formed header with random content and k payload bytes
   task automatic queue_random_frame(input int k, input bit bad_sum);
      logic [7:0]  t;
      logic [15:0] len;
      t = 8'($urandom);
      len = (k == 1) ? 16'($urandom_range(0, 3)) : 16'(k + 2);
      queue_frame(t, ~t, 16'($urandom), 16'($urandom), len, k, -1, 1'b1, bad_sum);
   endtask

   // Stimulus, then drain and verdict
   initial begin
      int unsigned random_start;
      int unsigned pick;
      logic [7:0]  t;

      // Directed: all-ones/all-zeros headers, length 0 and 2, bad complement,
      // bad checksum, back-to-back frames
      queue_frame(8'hFF, 8'h00, 16'hFFFF, 16'h0000, 16'h0000, 1, 255, 1'b1, 1'b0);
      rx_bytes_pending.push_back(8'h00);
      rx_bytes_pending.push_back(8'h00);
      queue_frame(8'h00, 8'hFF, 16'h0000, 16'hFFFF, 16'h0002, 1, 0, 1'b1, 1'b1);

      // One frame that fills the buffer exactly, one that overruns it
      queue_random_frame(BUFFER_DEPTH, 1'b0);
      queue_frame(8'h5A, 8'hA5, 16'($urandom), 16'($urandom),
                  16'($urandom_range(BUFFER_DEPTH + 3, 65535)),
                  BUFFER_DEPTH + 1, -1, 1'b0, 1'b0);

      // Mostly good frames, some bad checksums, broken pairs and stray bytes
      random_start = rx_bytes_pending.size();
      while (rx_bytes_pending.size() < random_start + 45) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            queue_random_frame(($urandom_range(9) == 0) ? $urandom_range(9, 24) :
                               $urandom_range(1, 8), 1'b0);
         end else if (pick < 80) begin
            queue_random_frame($urandom_range(1, 8), 1'b1);
         end else if (pick < 93) begin
            t = 8'($urandom);
            rx_bytes_pending.push_back(t);
            rx_bytes_pending.push_back(~t ^ 8'($urandom_range(1, 255)));
         end else begin
            rx_bytes_pending.push_back(8'($urandom));
         end
      end

      while (rx_bytes_pending.size() != 0 || req_valid || expected_beats.size() != 0)
         @(posedge clock);
      // catch any stray beats after the last expected one
      repeat (100) @(posedge clock);

      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Sender: new byte only once the current one is taken; random gaps
   always @(negedge clock) begin
      if (!reset && (!req_valid || byte_taken)) begin
         if (rx_bytes_pending.size() != 0 && (quiet || $urandom_range(99) >= 30)) begin
            req_rx_byte <= rx_bytes_pending.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off so the block backs up
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && bytes_in >= 60) begin
         hold_done <= 1'b1;
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 30);
      end
   end

   // Monitor: check results first, then feed the accepted byte to the
   // parser mirror; a result can never stem from a byte taken at this edge
   always @(posedge clock) begin : observe
      frame_beat_type want;
      if (reset) begin
         byte_taken <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               log_mismatch("result beat with none expected");
            end else begin
               want = expected_beats.pop_front();
               check_field("status", 16'(rsp_status), 16'(want.status));
               check_field("transaction", 16'(rsp_transaction), 16'(want.transaction));
               check_field("command_word", rsp_command_word, want.command_word);
               check_field("extra_word", rsp_extra_word, want.extra_word);
               check_field("payload_byte", 16'(rsp_payload_byte), 16'(want.payload_byte));
               check_field("byte_index", 16'(rsp_byte_index), 16'(want.byte_index));
               check_field("last", 16'(rsp_last), 16'(want.last));
            end
         end
         byte_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            parse_rx_byte(req_rx_byte);
            bytes_in <= bytes_in + 1;
         end
      end
   end

endmodule
